@@ sv/scf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

   // Command codes carried in the op field.
   localparam logic [2:0] OP_TARGET       = 3'd0;
   localparam logic [2:0] OP_SPEED        = 3'd1;
   localparam logic [2:0] OP_ACCEL        = 3'd2;
   localparam logic [2:0] OP_PWM          = 3'd3;
   localparam logic [2:0] OP_GET_POSITION = 3'd4;
   localparam logic [2:0] OP_GET_MOVING   = 3'd5;
   localparam logic [2:0] OP_GET_ERRORS   = 3'd6;
   localparam logic [2:0] OP_HOME         = 3'd7;

   // Protocol modes.
   localparam logic [1:0] MODE_COMPACT   = 2'd0;
   localparam logic [1:0] MODE_ADDRESSED = 2'd1;

   // Error codes of a result.
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_MODE  = 2'd1;
   localparam logic [1:0] ERR_MODEL = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PROTOCOL_MODE = 2'd0;
   localparam logic [1:0] CSR_DEVICE_NUMBER = 2'd1;
   localparam logic [1:0] CSR_SMALL_MODEL   = 2'd2;

   localparam logic [7:0] SYNC_BYTE           = 8'hAA;
   localparam logic [6:0] DEVICE_NUMBER_RESET = 7'd12;
   localparam int         MAX_FRAME_BYTES     = 7;
   localparam int         QUEUE_DEPTH         = 2;

   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  channel;
      logic [13:0] value;
      logic [13:0] pwm_period;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
      logic [1:0] error_code;
   } rsp_type;

   // One classified command: its frame bytes in send order (entry 0 first),
   // the index of the final byte, and the error code.
   typedef struct packed {
      logic [MAX_FRAME_BYTES-1:0][7:0] bytes;
      logic [2:0]                      last_idx;
      logic [1:0]                      err;
   } frame_type;

   function automatic logic [7:0] cmd_code(input logic [2:0] op);
      logic [7:0] code;
      unique case (op)
         OP_TARGET:       code = 8'h84;
         OP_SPEED:        code = 8'h87;
         OP_ACCEL:        code = 8'h89;
         OP_PWM:          code = 8'h8A;
         OP_GET_POSITION: code = 8'h90;
         OP_GET_MOVING:   code = 8'h93;
         OP_GET_ERRORS:   code = 8'hA1;
         OP_HOME:         code = 8'hA2;
         default:         code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ sv/servo_command_framer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Servo command framer: turns one servo controller command into its serial frame.
// Input channel: an item (op, channel, value, pwm_period) is taken at a rising edge
// where start is high and busy is low. busy rises only when the frame queue is full.
// Result channel: each frame byte is shown for exactly one cycle with rsp_strobe high,
// together with last (final byte of the frame) and error_code. The receiver cannot
// stall; bytes leave at one per cycle with no gaps inside a frame.
// Configuration: csr_valid/csr_index/csr_wdata write protocol_mode (0), device_number
// (1) or small_model (2); csr_ready is always high. Write only while the block is idle.
// Path: an accepted item's frame is written into the queue, then loaded into the serializer,
// which puts its first byte on the result ports; it waits while an earlier frame is sent.
// Throughput: one result byte per cycle from the single output port; a frame has one
// to seven bytes (addressed PWM is the longest).
// Items are taken every cycle while the queue has room, so short commands can arrive
// back to back and long frames are absorbed by the queue.
// Reset: clears the queue and the serializer and returns the registers to compact
// mode, device number 12, full model.
module servo_command_framer_core
   import scf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_strobe,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);

   frame_type front_frame;
   frame_type q_data;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   logic      accept;

   // Registers take a write in any cycle.
   assign csr_ready = 1'b1;

   assign busy   = q_full;
   assign accept = start && !q_full;

   // The front holds the configuration and builds a complete frame for each item.
   scf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .frame     (front_frame)
   );

   // The queue decouples command intake from byte output.
   scf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_frame),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // The back shifts each frame out one byte per cycle.
   scf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ sv/scf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scf_front
   import scf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata,
   input  wire req_type    req_data,
   output frame_type       frame
);

   logic [1:0] protocol_mode_ff, protocol_mode_in;
   logic [6:0] device_number_ff, device_number_in;
   logic       small_model_ff,   small_model_in;

   always_comb begin
      protocol_mode_in = protocol_mode_ff;
      device_number_in = device_number_ff;
      small_model_in   = small_model_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROTOCOL_MODE: protocol_mode_in = csr_wdata[1:0];
            CSR_DEVICE_NUMBER: device_number_in = csr_wdata;
            CSR_SMALL_MODEL:   small_model_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= MODE_COMPACT;
         device_number_ff <= DEVICE_NUMBER_RESET;
         small_model_ff   <= 1'b0;
      end else begin
         protocol_mode_ff <= protocol_mode_in;
         device_number_ff <= device_number_in;
         small_model_ff   <= small_model_in;
      end
   end

   // Build the whole frame at once; bytes are appended in send order.
   always_comb begin
      logic [2:0] n;
      logic [7:0] code;
      logic       has_channel;
      logic       has_value;
      logic       is_pwm;
      frame       = '0;
      n           = 3'd0;
      code        = cmd_code(req_data.op);
      is_pwm      = (req_data.op == OP_PWM);
      has_channel = (req_data.op == OP_TARGET) || (req_data.op == OP_SPEED) ||
                    (req_data.op == OP_ACCEL)  || (req_data.op == OP_GET_POSITION);
      has_value   = has_channel && (req_data.op != OP_GET_POSITION) || is_pwm;
      priority if (small_model_ff && (is_pwm || req_data.op == OP_GET_MOVING)) begin
         frame.err = ERR_MODEL;
      end else if (protocol_mode_ff != MODE_COMPACT &&
                   protocol_mode_ff != MODE_ADDRESSED) begin
         frame.err = ERR_MODE;
      end else begin
         if (protocol_mode_ff == MODE_COMPACT) begin
            frame.bytes[n] = code;
            n = n + 3'd1;
         end else begin
            frame.bytes[n] = SYNC_BYTE;
            n = n + 3'd1;
            frame.bytes[n] = {1'b0, device_number_ff};
            n = n + 3'd1;
            frame.bytes[n] = {1'b0, code[6:0]};
            n = n + 3'd1;
         end
         if (has_channel) begin
            frame.bytes[n] = {1'b0, req_data.channel};
            n = n + 3'd1;
         end
         if (has_value) begin
            frame.bytes[n] = {1'b0, req_data.value[6:0]};
            n = n + 3'd1;
            frame.bytes[n] = {1'b0, req_data.value[13:7]};
            n = n + 3'd1;
         end
         if (is_pwm) begin
            frame.bytes[n] = {1'b0, req_data.pwm_period[6:0]};
            n = n + 3'd1;
            frame.bytes[n] = {1'b0, req_data.pwm_period[13:7]};
            n = n + 3'd1;
         end
         frame.last_idx = n - 3'd1;
         frame.err      = ERR_OK;
      end
   end

endmodule

`default_nettype wire

@@ sv/scf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scf_queue
   import scf_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_data,
   output logic           full,
   input  wire logic      pop,
   output logic           pop_valid,
   output frame_type      pop_data
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   frame_type           mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff,  count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ sv/scf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scf_back
   import scf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_valid,
   input  wire frame_type q_data,
   output logic           q_pop,
   output logic           rsp_strobe,
   output rsp_type        rsp_data
);

   frame_type  cur_ff,    cur_in;
   logic [2:0] remain_ff, remain_in;
   logic       active_ff, active_in;
   logic       free;

   // The serializer can take the next frame when it is empty or sending its final byte.
   assign free  = !active_ff || (remain_ff == 3'd0);
   assign q_pop = q_valid && free;

   always_comb begin
      cur_in    = cur_ff;
      remain_in = remain_ff;
      active_in = active_ff;
      if (active_ff) begin
         cur_in.bytes = {8'h00, cur_ff.bytes[MAX_FRAME_BYTES-1:1]};
         remain_in    = remain_ff - 3'd1;
         if (remain_ff == 3'd0) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         cur_in    = q_data;
         remain_in = q_data.last_idx;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      remain_ff <= remain_in;
   end

   assign rsp_strobe          = active_ff;
   assign rsp_data.frame_byte = cur_ff.bytes[0];
   assign rsp_data.last       = (remain_ff == 3'd0);
   assign rsp_data.error_code = cur_ff.err;

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.error_code != ERR_OK |->
         rsp_data.last && rsp_data.frame_byte == 8'h00)
      else $error("error result is not a single zero byte");

   a_frame_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside a frame");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_valid && !active_ff |-> q_pop)
      else $error("idle serializer left a frame waiting");

endmodule

`default_nettype wire
